// ----- sv/rci_pkg.sv -----
package rci_pkg;

   localparam int COORD_W   = 16;
   localparam int RADIUS_W  = 15;
   localparam int FRAC_W    = 16;
   localparam int TIME_W    = 32;
   localparam int EXT_W     = COORD_W + 1;
   localparam int XD_W      = EXT_W + COORD_W;
   localparam int XX_W      = 2 * EXT_W;
   localparam int DD_W      = 2 * COORD_W;
   localparam int RR_W      = 2 * RADIUS_W;
   localparam int A_W       = 2 * COORD_W;
   localparam int H_W       = 2 * EXT_W;
   localparam int HMAG_W    = 2 * COORD_W;
   localparam int CMAG_W    = 2 * COORD_W + 1;
   localparam int PROD_W    = 2 * A_W;
   localparam int DISC_W    = PROD_W + 1;
   localparam int ROOT_W    = (DISC_W + 2 * FRAC_W + 1) / 2;
   localparam int RAD_W     = 2 * ROOT_W;
   localparam int SQREM_W   = ROOT_W + 3;
   localparam int K_W       = HMAG_W + FRAC_W;
   localparam int NUM_W     = ROOT_W + 1;
   localparam int DREM_W    = A_W + 1;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS   = 2'd2;

   localparam logic [TIME_W-1:0] TIME_MAX       = {1'b0, {(TIME_W-1){1'b1}}};
   localparam logic [TIME_W-1:0] TIME_MINUS_ONE = {{(TIME_W-FRAC_W){1'b1}}, {FRAC_W{1'b0}}};

   typedef struct packed {
      logic             nohit;
      logic             single;
      logic             h_pos;
      logic [A_W-1:0]   a;
      logic [K_W-1:0]   k;
   } root_side_type;

   typedef struct packed {
      logic nohit;
      logic single;
   } div_side_type;

endpackage

// ----- sv/rci_front.sv -----
module rci_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                in_valid,
   input  logic signed [rci_pkg::COORD_W-1:0]  pos_x,
   input  logic signed [rci_pkg::COORD_W-1:0]  pos_y,
   input  logic signed [rci_pkg::COORD_W-1:0]  dir_x,
   input  logic signed [rci_pkg::COORD_W-1:0]  dir_y,
   input  logic signed [rci_pkg::COORD_W-1:0]  center_x,
   input  logic signed [rci_pkg::COORD_W-1:0]  center_y,
   input  logic        [rci_pkg::RADIUS_W-1:0] radius,
   output logic                                out_valid,
   output logic        [rci_pkg::DISC_W-1:0]   out_disc,
   output rci_pkg::root_side_type              out_side
);

   typedef struct packed {
      logic a_zero;
      logic h_pos;
      logic c_pos;
      logic c_neg;
   } flags_type;

   // stage 1: offset from center
   logic v1_ff;
   logic signed [rci_pkg::EXT_W-1:0] ex1_ff, ey1_ff;
   logic signed [rci_pkg::COORD_W-1:0] dx1_ff, dy1_ff;
   logic [rci_pkg::RADIUS_W-1:0] r1_ff;
   // stage 2: products
   logic v2_ff;
   logic signed [rci_pkg::XD_W-1:0] exdx2_ff, eydy2_ff;
   logic signed [rci_pkg::XX_W-1:0] exex2_ff, eyey2_ff;
   logic signed [rci_pkg::DD_W-1:0] dxdx2_ff, dydy2_ff;
   logic [rci_pkg::RR_W-1:0] rr2_ff;
   // stage 3: quadratic coefficients
   logic v3_ff;
   logic [rci_pkg::A_W-1:0] a3_ff;
   logic signed [rci_pkg::H_W-1:0] h3_ff, c3_ff;
   // stage 4: magnitudes and signs
   logic v4_ff;
   logic [rci_pkg::A_W-1:0] a4_ff;
   logic [rci_pkg::HMAG_W-1:0] habs4_ff;
   logic [rci_pkg::CMAG_W-1:0] cabs4_ff;
   flags_type f4_ff;
   // stage 5: h^2 and low part of a*|c|
   logic v5_ff;
   logic [rci_pkg::A_W-1:0] a5_ff;
   logic [rci_pkg::HMAG_W-1:0] habs5_ff;
   logic [rci_pkg::PROD_W-1:0] hh5_ff, acl5_ff;
   logic ctop5_ff;
   flags_type f5_ff;
   // stage 6: full a*|c|
   logic v6_ff;
   logic [rci_pkg::A_W-1:0] a6_ff;
   logic [rci_pkg::HMAG_W-1:0] habs6_ff;
   logic [rci_pkg::PROD_W-1:0] hh6_ff, ac6_ff;
   flags_type f6_ff;
   // stage 7: discriminant and case decision
   logic v7_ff;
   logic [rci_pkg::DISC_W-1:0] disc7_ff;
   rci_pkg::root_side_type side7_ff;

   logic [rci_pkg::DISC_W-1:0] disc7_in;
   rci_pkg::root_side_type side7_in;
   logic hh_lt_ac;

   always_comb begin
      hh_lt_ac = hh6_ff < ac6_ff;
      if (f6_ff.c_pos) begin
         disc7_in = rci_pkg::DISC_W'(hh6_ff) - rci_pkg::DISC_W'(ac6_ff);
      end else begin
         disc7_in = rci_pkg::DISC_W'(hh6_ff) + rci_pkg::DISC_W'(ac6_ff);
      end
      side7_in.nohit  = f6_ff.a_zero | (f6_ff.c_pos & hh_lt_ac) | (f6_ff.c_pos & f6_ff.h_pos);
      side7_in.single = f6_ff.h_pos | f6_ff.c_neg;
      side7_in.h_pos  = f6_ff.h_pos;
      side7_in.a      = a6_ff;
      side7_in.k      = {habs6_ff, {rci_pkg::FRAC_W{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ex1_ff <= rci_pkg::EXT_W'(pos_x) - rci_pkg::EXT_W'(center_x);
         ey1_ff <= rci_pkg::EXT_W'(pos_y) - rci_pkg::EXT_W'(center_y);
         dx1_ff <= dir_x;
         dy1_ff <= dir_y;
         r1_ff  <= radius;

         exdx2_ff <= rci_pkg::XD_W'(ex1_ff) * rci_pkg::XD_W'(dx1_ff);
         eydy2_ff <= rci_pkg::XD_W'(ey1_ff) * rci_pkg::XD_W'(dy1_ff);
         exex2_ff <= rci_pkg::XX_W'(ex1_ff) * rci_pkg::XX_W'(ex1_ff);
         eyey2_ff <= rci_pkg::XX_W'(ey1_ff) * rci_pkg::XX_W'(ey1_ff);
         dxdx2_ff <= rci_pkg::DD_W'(dx1_ff) * rci_pkg::DD_W'(dx1_ff);
         dydy2_ff <= rci_pkg::DD_W'(dy1_ff) * rci_pkg::DD_W'(dy1_ff);
         rr2_ff   <= rci_pkg::RR_W'(r1_ff) * rci_pkg::RR_W'(r1_ff);

         a3_ff <= rci_pkg::A_W'(dxdx2_ff) + rci_pkg::A_W'(dydy2_ff);
         h3_ff <= rci_pkg::H_W'(exdx2_ff) + rci_pkg::H_W'(eydy2_ff);
         c3_ff <= exex2_ff + eyey2_ff - $signed(rci_pkg::H_W'(rr2_ff));

         a4_ff       <= a3_ff;
         habs4_ff    <= h3_ff[rci_pkg::H_W-1] ? rci_pkg::HMAG_W'(-h3_ff)
                                              : rci_pkg::HMAG_W'(h3_ff);
         cabs4_ff    <= c3_ff[rci_pkg::H_W-1] ? rci_pkg::CMAG_W'(-c3_ff)
                                              : rci_pkg::CMAG_W'(c3_ff);
         f4_ff.a_zero <= a3_ff == '0;
         f4_ff.h_pos  <= !h3_ff[rci_pkg::H_W-1] && (h3_ff != '0);
         f4_ff.c_pos  <= !c3_ff[rci_pkg::H_W-1] && (c3_ff != '0);
         f4_ff.c_neg  <= c3_ff[rci_pkg::H_W-1];

         a5_ff    <= a4_ff;
         habs5_ff <= habs4_ff;
         hh5_ff   <= rci_pkg::PROD_W'(habs4_ff) * rci_pkg::PROD_W'(habs4_ff);
         acl5_ff  <= rci_pkg::PROD_W'(a4_ff) * rci_pkg::PROD_W'(cabs4_ff[rci_pkg::A_W-1:0]);
         ctop5_ff <= cabs4_ff[rci_pkg::CMAG_W-1];
         f5_ff    <= f4_ff;

         a6_ff    <= a5_ff;
         habs6_ff <= habs5_ff;
         hh6_ff   <= hh5_ff;
         ac6_ff   <= acl5_ff + (ctop5_ff ? {a5_ff, {rci_pkg::A_W{1'b0}}} : '0);
         f6_ff    <= f5_ff;

         disc7_ff <= disc7_in;
         side7_ff <= side7_in;
      end
   end

   assign out_valid = v7_ff;
   assign out_disc  = disc7_ff;
   assign out_side  = side7_ff;

endmodule

// ----- sv/rci_sqrt.sv -----
module rci_sqrt (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic [rci_pkg::DISC_W-1:0]        in_disc,
   input  rci_pkg::root_side_type            in_side,
   output logic                              out_valid,
   output logic [rci_pkg::ROOT_W-1:0]        out_root,
   output rci_pkg::root_side_type            out_side
);

   logic                          v_ff    [rci_pkg::ROOT_W];
   logic [rci_pkg::SQREM_W-1:0]   rem_ff  [rci_pkg::ROOT_W];
   logic [rci_pkg::ROOT_W-1:0]    q_ff    [rci_pkg::ROOT_W];
   logic [rci_pkg::DISC_W-1:0]    disc_ff [rci_pkg::ROOT_W];
   rci_pkg::root_side_type        side_ff [rci_pkg::ROOT_W];

   // one root bit per stage, radicand is disc scaled by 2^(2*frac)
   for (genvar j = 0; j < rci_pkg::ROOT_W; j++) begin : g_step
      logic                        v_prev;
      logic [rci_pkg::SQREM_W-1:0] rem_prev, rem_sh, trial, rem_in;
      logic [rci_pkg::ROOT_W-1:0]  q_prev, q_in;
      logic [rci_pkg::DISC_W-1:0]  disc_prev;
      rci_pkg::root_side_type      side_prev;
      logic [rci_pkg::RAD_W-1:0]   rad;

      if (j == 0) begin : g_first
         assign v_prev    = in_valid;
         assign rem_prev  = '0;
         assign q_prev    = '0;
         assign disc_prev = in_disc;
         assign side_prev = in_side;
      end else begin : g_next
         assign v_prev    = v_ff[j-1];
         assign rem_prev  = rem_ff[j-1];
         assign q_prev    = q_ff[j-1];
         assign disc_prev = disc_ff[j-1];
         assign side_prev = side_ff[j-1];
      end

      assign rad = rci_pkg::RAD_W'(disc_prev) << (2 * rci_pkg::FRAC_W);

      always_comb begin
         rem_sh = {rem_prev[rci_pkg::SQREM_W-3:0], rad[2*(rci_pkg::ROOT_W-1-j) +: 2]};
         trial  = rci_pkg::SQREM_W'({q_prev, 2'b01});
         if (rem_sh >= trial) begin
            rem_in = rem_sh - trial;
            q_in   = {q_prev[rci_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            q_in   = {q_prev[rci_pkg::ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else if (en) begin
            v_ff[j] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j]  <= rem_in;
            q_ff[j]    <= q_in;
            disc_ff[j] <= disc_prev;
            side_ff[j] <= side_prev;
         end
      end
   end

   assign out_valid = v_ff[rci_pkg::ROOT_W-1];
   assign out_root  = q_ff[rci_pkg::ROOT_W-1];
   assign out_side  = side_ff[rci_pkg::ROOT_W-1];

endmodule

// ----- sv/rci_div.sv -----
module rci_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_valid,
   input  logic [rci_pkg::NUM_W-1:0]        in_num1,
   input  logic [rci_pkg::NUM_W-1:0]        in_num2,
   input  logic [rci_pkg::A_W-1:0]          in_den,
   input  rci_pkg::div_side_type            in_side,
   output logic                             out_valid,
   output logic [rci_pkg::TIME_W-1:0]       out_q1,
   output logic [rci_pkg::TIME_W-1:0]       out_q2,
   output rci_pkg::div_side_type            out_side
);

   localparam int LAST = rci_pkg::NUM_W - 1;

   logic                          v_ff    [rci_pkg::NUM_W];
   logic [rci_pkg::DREM_W-1:0]    rem1_ff [rci_pkg::NUM_W];
   logic [rci_pkg::DREM_W-1:0]    rem2_ff [rci_pkg::NUM_W];
   logic [rci_pkg::TIME_W-2:0]    q1_ff   [rci_pkg::NUM_W];
   logic [rci_pkg::TIME_W-2:0]    q2_ff   [rci_pkg::NUM_W];
   logic                          sat1_ff [rci_pkg::NUM_W];
   logic                          sat2_ff [rci_pkg::NUM_W];
   logic [rci_pkg::NUM_W-1:0]     num1_ff [rci_pkg::NUM_W];
   logic [rci_pkg::NUM_W-1:0]     num2_ff [rci_pkg::NUM_W];
   logic [rci_pkg::A_W-1:0]       den_ff  [rci_pkg::NUM_W];
   rci_pkg::div_side_type         side_ff [rci_pkg::NUM_W];

   // restoring step: returns {new remainder, quotient bit}
   function automatic logic [rci_pkg::DREM_W:0] div_step(
      input logic [rci_pkg::DREM_W-1:0] rem,
      input logic                       nbit,
      input logic [rci_pkg::A_W-1:0]    den
   );
      logic [rci_pkg::DREM_W-1:0] sh;
      logic                       ge;
      sh = {rem[rci_pkg::DREM_W-2:0], nbit};
      ge = sh >= rci_pkg::DREM_W'(den);
      return {ge ? sh - rci_pkg::DREM_W'(den) : sh, ge};
   endfunction

   for (genvar j = 0; j < rci_pkg::NUM_W; j++) begin : g_step
      logic                       v_prev, sat1_prev, sat2_prev;
      logic [rci_pkg::DREM_W-1:0] rem1_prev, rem2_prev;
      logic [rci_pkg::TIME_W-2:0] q1_prev, q2_prev;
      logic [rci_pkg::NUM_W-1:0]  num1_prev, num2_prev;
      logic [rci_pkg::A_W-1:0]    den_prev;
      rci_pkg::div_side_type      side_prev;
      logic [rci_pkg::DREM_W:0]   st1, st2;

      if (j == 0) begin : g_first
         assign v_prev    = in_valid;
         assign sat1_prev = 1'b0;
         assign sat2_prev = 1'b0;
         assign rem1_prev = '0;
         assign rem2_prev = '0;
         assign q1_prev   = '0;
         assign q2_prev   = '0;
         assign num1_prev = in_num1;
         assign num2_prev = in_num2;
         assign den_prev  = in_den;
         assign side_prev = in_side;
      end else begin : g_next
         assign v_prev    = v_ff[j-1];
         assign sat1_prev = sat1_ff[j-1];
         assign sat2_prev = sat2_ff[j-1];
         assign rem1_prev = rem1_ff[j-1];
         assign rem2_prev = rem2_ff[j-1];
         assign q1_prev   = q1_ff[j-1];
         assign q2_prev   = q2_ff[j-1];
         assign num1_prev = num1_ff[j-1];
         assign num2_prev = num2_ff[j-1];
         assign den_prev  = den_ff[j-1];
         assign side_prev = side_ff[j-1];
      end

      assign st1 = div_step(rem1_prev, num1_prev[LAST-j], den_prev);
      assign st2 = div_step(rem2_prev, num2_prev[LAST-j], den_prev);

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else if (en) begin
            v_ff[j] <= v_prev;
         end
      end

      // a one shifted past the top quotient bit means saturation
      always_ff @(posedge clock) begin
         if (en) begin
            rem1_ff[j] <= st1[rci_pkg::DREM_W:1];
            rem2_ff[j] <= st2[rci_pkg::DREM_W:1];
            q1_ff[j]   <= {q1_prev[rci_pkg::TIME_W-3:0], st1[0]};
            q2_ff[j]   <= {q2_prev[rci_pkg::TIME_W-3:0], st2[0]};
            sat1_ff[j] <= sat1_prev | q1_prev[rci_pkg::TIME_W-2];
            sat2_ff[j] <= sat2_prev | q2_prev[rci_pkg::TIME_W-2];
            num1_ff[j] <= num1_prev;
            num2_ff[j] <= num2_prev;
            den_ff[j]  <= den_prev;
            side_ff[j] <= side_prev;
         end
      end
   end

   assign out_valid = v_ff[LAST];
   assign out_q1    = sat1_ff[LAST] ? rci_pkg::TIME_MAX : {1'b0, q1_ff[LAST]};
   assign out_q2    = sat2_ff[LAST] ? rci_pkg::TIME_MAX : {1'b0, q2_ff[LAST]};
   assign out_side  = side_ff[LAST];

endmodule

// ----- sv/ray_circle_intersection.sv -----
// Ray against circle test, one ray word accepted per clock when the result side keeps up.
// The circle center and radius are set through the csr port; the user must write them
// only while the block is idle, the block itself does not enforce it. Each ray goes
// through a fixed pipeline of 108 register stages: 7 to form the quadratic and its
// discriminant, 49 for the square root (one root bit per stage), 1 to form the numerators,
// 50 for the two parallel dividers (one quotient bit per stage) and the output register.
// Throughput is one word per cycle; while a result word waits with rsp_tready low the
// whole pipeline holds and req_tready drops.
// Times are unsigned-valued Q16.16, saturated to 0x7fffffff; a start point inside the circle
// reports the exit time first and -1.0 as second time, and a miss reports zeros.
module ray_circle_intersection (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // ray_pos_x, ray_pos_y, ray_dir_x, ray_dir_y
   input  logic [4*rci_pkg::COORD_W-1:0]      req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // time_first, time_second
   output logic [2*rci_pkg::TIME_W-1:0]       rsp_tdata,
   // hit
   output logic                               rsp_tuser,
   input  logic                               csr_we,
   input  logic [rci_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rci_pkg::COORD_W-1:0]        csr_wdata
);

   logic signed [rci_pkg::COORD_W-1:0] center_x_ff, center_y_ff;
   logic [rci_pkg::RADIUS_W-1:0]       radius_ff;

   logic en;

   logic                       fr_valid;
   logic [rci_pkg::DISC_W-1:0] fr_disc;
   rci_pkg::root_side_type     fr_side;

   logic                       sq_valid;
   logic [rci_pkg::ROOT_W-1:0] sq_root;
   rci_pkg::root_side_type     sq_side;

   logic                       nm_valid_ff;
   logic [rci_pkg::NUM_W-1:0]  num1_ff, num2_ff;
   logic [rci_pkg::A_W-1:0]    den_ff;
   rci_pkg::div_side_type      nm_side_ff;
   logic [rci_pkg::NUM_W-1:0]  num1_in, num2_in, k_ext, root_ext;

   logic                        dv_valid;
   logic [rci_pkg::TIME_W-1:0]  dv_q1, dv_q2;
   rci_pkg::div_side_type       dv_side;

   logic                        rsp_valid_ff, hit_ff;
   logic [rci_pkg::TIME_W-1:0]  time_first_ff, time_second_ff;

   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         radius_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            rci_pkg::CSR_CENTER_X: center_x_ff <= csr_wdata;
            rci_pkg::CSR_CENTER_Y: center_y_ff <= csr_wdata;
            rci_pkg::CSR_RADIUS:   radius_ff   <= csr_wdata[rci_pkg::RADIUS_W-1:0];
            default: ;
         endcase
      end
   end

   rci_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .pos_x     (req_tdata[0*rci_pkg::COORD_W +: rci_pkg::COORD_W]),
      .pos_y     (req_tdata[1*rci_pkg::COORD_W +: rci_pkg::COORD_W]),
      .dir_x     (req_tdata[2*rci_pkg::COORD_W +: rci_pkg::COORD_W]),
      .dir_y     (req_tdata[3*rci_pkg::COORD_W +: rci_pkg::COORD_W]),
      .center_x  (center_x_ff),
      .center_y  (center_y_ff),
      .radius    (radius_ff),
      .out_valid (fr_valid),
      .out_disc  (fr_disc),
      .out_side  (fr_side)
   );

   rci_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fr_valid),
      .in_disc   (fr_disc),
      .in_side   (fr_side),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // numerators: -h*2^f +- s, sign of h picks the form
   always_comb begin
      k_ext    = rci_pkg::NUM_W'(sq_side.k);
      root_ext = rci_pkg::NUM_W'(sq_root);
      num2_in  = k_ext + root_ext;
      if (sq_side.single) begin
         num1_in = sq_side.h_pos ? root_ext - k_ext : k_ext + root_ext;
      end else begin
         num1_in = k_ext - root_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nm_valid_ff <= 1'b0;
      end else if (en) begin
         nm_valid_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num1_ff           <= num1_in;
         num2_ff           <= num2_in;
         den_ff            <= sq_side.a;
         nm_side_ff.nohit  <= sq_side.nohit;
         nm_side_ff.single <= sq_side.single;
      end
   end

   rci_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (nm_valid_ff),
      .in_num1   (num1_ff),
      .in_num2   (num2_ff),
      .in_den    (den_ff),
      .in_side   (nm_side_ff),
      .out_valid (dv_valid),
      .out_q1    (dv_q1),
      .out_q2    (dv_q2),
      .out_side  (dv_side)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hit_ff         <= !dv_side.nohit;
         time_first_ff  <= dv_side.nohit ? '0 : dv_q1;
         time_second_ff <= dv_side.nohit ? '0 :
                           (dv_side.single ? rci_pkg::TIME_MINUS_ONE : dv_q2);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {time_second_ff, time_first_ff};
   assign rsp_tuser  = hit_ff;

   a_miss_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("miss word carries nonzero times");

   a_first_nonneg : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[rci_pkg::TIME_W-1])
      else $error("first time negative");

   a_order : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser &&
      rsp_tdata[2*rci_pkg::TIME_W-1:rci_pkg::TIME_W] != rci_pkg::TIME_MINUS_ONE |->
      rsp_tdata[rci_pkg::TIME_W-1:0] <= rsp_tdata[2*rci_pkg::TIME_W-1:rci_pkg::TIME_W])
      else $error("intersection times out of order");

   a_stall : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without output backpressure");

endmodule

// ----- dv/tb_ray_circle_intersection.sv -----
`timescale 1ns / 1ps

module tb_ray_circle_intersection;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int LONG_HOLD      = 400;
   localparam int DRAIN_CYCLES   = 150;

   typedef struct packed {
      logic signed [rci_pkg::COORD_W-1:0] dir_y;
      logic signed [rci_pkg::COORD_W-1:0] dir_x;
      logic signed [rci_pkg::COORD_W-1:0] pos_y;
      logic signed [rci_pkg::COORD_W-1:0] pos_x;
   } ray_word_type;

   typedef struct {
      logic                       hit;
      logic [rci_pkg::TIME_W-1:0] t_first;
      logic [rci_pkg::TIME_W-1:0] t_second;
   } crossing_type;

   class crossing_scoreboard;
      crossing_type      pending_crossings[$];
      logic signed [15:0] circ_cx, circ_cy;
      logic [14:0]       circ_r;
      int                mismatches;
      int                rays_seen, hits_seen, inside_seen;

      function new();
         circ_cx = 0; circ_cy = 0; circ_r = 0;
         mismatches = 0; rays_seen = 0; hits_seen = 0; inside_seen = 0;
      endfunction

      function void set_reg(logic [rci_pkg::CSR_IDX_W-1:0] idx,
                            logic [rci_pkg::COORD_W-1:0] val);
         if (idx == rci_pkg::CSR_CENTER_X) circ_cx = val;
         else if (idx == rci_pkg::CSR_CENTER_Y) circ_cy = val;
         else if (idx == rci_pkg::CSR_RADIUS) circ_r = val[14:0];
      endfunction

      function logic [191:0] floor_sqrt(logic [191:0] v);
         logic [191:0] res, bitv, n;
         res = 0;
         n = v;
         bitv = 192'b1 << 190;
         while (bitv > n) bitv = bitv >> 2;
         while (bitv != 0) begin
            if (n >= res + bitv) begin
               n = n - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv = bitv >> 2;
         end
         return res;
      endfunction

      function logic [rci_pkg::TIME_W-1:0] sat_div(logic [191:0] num, logic [191:0] den);
         logic [191:0] q;
         q = num / den;
         if (q > 192'(rci_pkg::TIME_MAX)) return rci_pkg::TIME_MAX;
         return q[rci_pkg::TIME_W-1:0];
      endfunction

      function void note_ray(ray_word_type ray);
         crossing_type exp_c;
         longint       ex, ey, dx, dy, a, h, c, rr;
         logic [191:0] habs, cabs, wa, hh, ac, disc, s, k;
         exp_c = '{hit: 1'b0, t_first: '0, t_second: '0};
         dx = longint'(ray.dir_x);
         dy = longint'(ray.dir_y);
         ex = longint'(ray.pos_x) - longint'(circ_cx);
         ey = longint'(ray.pos_y) - longint'(circ_cy);
         rr = longint'({1'b0, circ_r});
         a = dx * dx + dy * dy;
         h = ex * dx + ey * dy;
         c = ex * ex + ey * ey - rr * rr;
         habs = (h < 0) ? 192'(-h) : 192'(h);
         cabs = (c < 0) ? 192'(-c) : 192'(c);
         wa = 192'(a);
         hh = habs * habs;
         ac = wa * cabs;
         rays_seen++;
         if (a != 0 && !(c > 0 && hh < ac) && !(h > 0 && c > 0)) begin
            disc = (c > 0) ? hh - ac : hh + ac;
            s = floor_sqrt(disc << (2 * rci_pkg::FRAC_W));
            k = habs << rci_pkg::FRAC_W;
            exp_c.hit = 1'b1;
            hits_seen++;
            if (h > 0 || c < 0) begin
               exp_c.t_first = sat_div((h <= 0) ? k + s : s - k, wa);
               exp_c.t_second = rci_pkg::TIME_MINUS_ONE;
               inside_seen++;
            end else begin
               exp_c.t_first = sat_div(k - s, wa);
               exp_c.t_second = sat_div(k + s, wa);
            end
         end
         pending_crossings.push_back(exp_c);
      endfunction

      function void check_result(logic [2*rci_pkg::TIME_W-1:0] data, logic hit);
         crossing_type exp_c;
         if (pending_crossings.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: result with nothing pending: hit=%b data=%h", $realtime, hit, data);
            return;
         end
         exp_c = pending_crossings.pop_front();
         if (hit !== exp_c.hit || data[rci_pkg::TIME_W-1:0] !== exp_c.t_first ||
             data[2*rci_pkg::TIME_W-1:rci_pkg::TIME_W] !== exp_c.t_second) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: mismatch exp hit=%b t1=%h t2=%h got hit=%b t1=%h t2=%h",
                        $realtime, exp_c.hit, exp_c.t_first, exp_c.t_second,
                        hit, data[rci_pkg::TIME_W-1:0],
                        data[2*rci_pkg::TIME_W-1:rci_pkg::TIME_W]);
         end
      endfunction
   endclass

   logic                              clock;
   logic                              reset;
   logic                              req_tvalid;
   logic                              req_tready;
   logic [4*rci_pkg::COORD_W-1:0]     req_tdata;
   logic                              rsp_tvalid;
   logic                              rsp_tready;
   logic [2*rci_pkg::TIME_W-1:0]      rsp_tdata;
   logic                              rsp_tuser;
   logic                              csr_we;
   logic [rci_pkg::CSR_IDX_W-1:0]     csr_index;
   logic [rci_pkg::COORD_W-1:0]       csr_wdata;

   crossing_scoreboard sb;
   bit  hold_request;
   int  idle_cycles;
   bit  timed_out;

   ray_circle_intersection dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial sb = new();

   // input and result monitors, sampled at the edge before any update
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) sb.note_ray(ray_word_type'(req_tdata));
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset || csr_we)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      idle_cycles = 0;
      timed_out = 1'b0;
      wait (idle_cycles >= WATCHDOG_LIMIT);
      timed_out = 1'b1;
      $display("watchdog expired, %0d results pending", sb.pending_crossings.size());
      $display("*** FAILED ***");
      $finish;
   end

   // receiver: its own stall pattern, plus a long hold-off on request
   initial begin
      int pattern, phase_left, hold_left;
      rsp_tready = 1'b0;
      pattern = 0;
      phase_left = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = LONG_HOLD;
         end
         if (phase_left == 0) begin
            pattern = $urandom_range(0, 3);
            phase_left = $urandom_range(16, 96);
         end
         phase_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (pattern)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 3) != 0);
               2: rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= ($urandom_range(0, 7) < 5);
            endcase
         end
      end
   end

   task automatic write_reg(logic [rci_pkg::CSR_IDX_W-1:0] idx,
                            logic [rci_pkg::COORD_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.set_reg(idx, val);
      csr_we    <= 1'b0;
   endtask

   task automatic wait_drained();
      while (sb.pending_crossings.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_circle(int cx, int cy, int r);
      wait_drained();
      write_reg(rci_pkg::CSR_CENTER_X, cx[15:0]);
      write_reg(rci_pkg::CSR_CENTER_Y, cy[15:0]);
      write_reg(rci_pkg::CSR_RADIUS, {1'b0, r[14:0]});
   endtask

   // send one ray word and hold it until accepted
   task automatic send_ray(int px, int py, int dx, int dy);
      ray_word_type w;
      w.pos_x = px[15:0];
      w.pos_y = py[15:0];
      w.dir_x = dx[15:0];
      w.dir_y = dy[15:0];
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic sender_gap();
      req_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clock);
   endtask

   function automatic int clamp16(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   task automatic random_rays(int count, int cx, int cy, int r);
      int burst, kind, px, py, dx, dy, spread, scale;
      burst = 0;
      for (int n = 0; n < count; n++) begin
         if (burst == 0) begin
            if ($urandom_range(0, 3) != 0) sender_gap();
            burst = $urandom_range(1, 24);
         end
         burst--;
         kind = $urandom_range(0, 9);
         if (kind < 2) begin
            px = $signed(16'($urandom)); py = $signed(16'($urandom));
            dx = $signed(16'($urandom)); dy = $signed(16'($urandom));
         end else begin
            // aimed near the circle, often from inside, direction roughly at center (kind 9: small random direction)
            spread = (kind < 5) ? r + 1 : 3 * r + 64;
            px = clamp16(cx + $signed($urandom_range(0, 2 * spread)) - spread);
            py = clamp16(cy + $signed($urandom_range(0, 2 * spread)) - spread);
            scale = $urandom_range(0, 2);
            dx = clamp16(((cx - px) >>> scale) + $signed($urandom_range(0, 64)) - 32);
            dy = clamp16(((cy - py) >>> scale) + $signed($urandom_range(0, 64)) - 32);
            if (kind == 9) begin
               dx = $signed($urandom_range(0, 6)) - 3;
               dy = $signed($urandom_range(0, 6)) - 3;
            end
         end
         send_ray(px, py, dx, dy);
      end
      req_tvalid <= 1'b0;
   endtask

   initial begin
      int cx, cy, r;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      csr_we       = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      hold_request = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset circle is a point at the origin
      send_ray(-10, 0, 1, 0);
      send_ray(0, 0, 0, 0);
      send_ray(0, 0, 1, 1);
      req_tvalid <= 1'b0;

      set_circle(0, 0, 100);
      send_ray(-1000, 0, 1, 0);           // two crossings ahead
      send_ray(0, 0, 1, 0);               // start inside
      send_ray(-1000, 100, 1, 0);         // tangent
      send_ray(1000, 0, 1, 0);            // circle behind
      send_ray(-1000, 500, 1, 0);         // clean miss
      send_ray(100, 0, 1, 0);             // start on the edge, leaving
      send_ray(-100, 0, 1, 0);            // start on the edge, entering
      send_ray(5, 5, 0, 0);               // zero direction
      send_ray(-32768, 0, 1, 0);          // time saturates
      send_ray(-32768, -32768, 32767, 32767);
      send_ray(32767, 32767, -32768, -32768);
      send_ray(-32768, 0, -32768, 0);
      send_ray(0, -500, 0, 3);
      req_tvalid <= 1'b0;

      set_circle(-32768, 32767, 32767);
      send_ray(32767, -32768, -32768, 32767);
      send_ray(-32768, 32767, 1, 0);
      send_ray(32767, -32768, -1, 1);
      send_ray(0, 0, -32768, -32768);
      req_tvalid <= 1'b0;

      set_circle(32767, -32768, 0);
      send_ray(-32768, 32767, 32767, -32768);
      send_ray(32767, -32768, 0, 1);
      req_tvalid <= 1'b0;

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin cx = 0; cy = 0; r = 100; end
            1: begin cx = -32768; cy = 32767; r = 32767; end
            2: begin cx = 32767; cy = -32768; r = 0; end
            default: begin
               cx = $signed(16'($urandom));
               cy = $signed(16'($urandom));
               r = $urandom_range(0, (ph == 5) ? 40 : 32767);
            end
         endcase
         set_circle(cx, cy, r);
         // the block fills while the receiver holds off
         if (ph == 3) hold_request = 1'b1;
         random_rays(140, cx, cy, r);
      end

      wait_drained();
      if (timed_out) begin
         $display("*** FAILED ***");
      end else begin
         $display("covered %0d rays against the reset circle and 9 written ones", sb.rays_seen);
         $display("%0d of them hit, %0d started inside or on the edge",
                  sb.hits_seen, sb.inside_seen);
         if (sb.mismatches == 0 && sb.pending_crossings.size() == 0) begin
            $display("*** PASSED ***");
         end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("*** FAILED ***");
         end
      end
      $finish;
   end

endmodule
